// ===== src/wrapped_angle_lowpass_filter_defines.svh =====
// Assertion macros shared by the wrapped-angle low-pass filter RTL.
`ifndef WRAPPED_ANGLE_LOWPASS_FILTER_DEFINES_SVH
`define WRAPPED_ANGLE_LOWPASS_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define WAL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define WAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/wal_pkg.sv =====
// Shared constants and types of the wrapped-angle low-pass filter.
`timescale 1ns / 1ps

package wal_pkg;

	localparam int JOINT_COUNT = 7;
	localparam int JIDX_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int CNT_W       = $clog2(JOINT_COUNT + 2);

	localparam int KIND_W  = 2;
	localparam int JOINT_W = 3;
	localparam int ANGLE_W = 16;
	localparam int SLOT_W  = 3;
	localparam int GAIN_W  = 16;
	localparam int DZ_W    = 13;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// Q2.13 radians.
	localparam int PI_Q     = 25736;
	localparam int TWO_PI_Q = 51472;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd9830;
	localparam logic [DZ_W-1:0]   DZ_RESET   = 13'd8;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET_TARGET   = 2'd0,
		KIND_SET_MEASURED = 2'd1,
		KIND_SET_GRIPPER  = 2'd2,
		KIND_TICK         = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN      = 1'd0,
		REG_DEAD_ZONE = 1'd1
	} reg_idx_t;

endpackage

// ===== src/wal_in_if.sv =====
// Input channel of the wrapped-angle low-pass filter.
`timescale 1ns / 1ps

interface wal_in_if;
	import wal_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic [JOINT_W-1:0]        joint;
	logic signed [ANGLE_W-1:0] angle;

	modport source (output valid, output kind, output joint, output angle, input ready);
	modport sink (input valid, input kind, input joint, input angle, output ready);
endinterface

// ===== src/wal_out_if.sv =====
// Result channel of the wrapped-angle low-pass filter.
`timescale 1ns / 1ps

interface wal_out_if;
	import wal_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [SLOT_W-1:0]         slot;
	logic signed [ANGLE_W-1:0] position;
	logic                      last;

	modport source (output valid, output slot, output position, output last, input ready);
	modport sink (input valid, input slot, input position, input last, output ready);
endinterface

// ===== src/wrapped_angle_lowpass_filter.sv =====
// Top level of the wrapped-angle low-pass filter (seven joints plus a gripper).
//
//   Channel    Direction  Words                           Handshake
//   sample     in         kind, joint, angle              valid/ready
//   result     out        slot, position, last            valid/ready
//   wr_*       in         wr_index, wr_data               wr_en, no back-pressure
//
// A set-target, set-measured or set-gripper word is taken and yields nothing.
// A tick that runs the filter yields eight words, one per cycle when result.ready stays
// high; the eight slots are walked one entry per cycle, stalls apart, through the single
// read port of the state memories, then through the four register stages of the joint
// pipeline; sample.ready stays low from the tick until the last word has been taken.
// Reset clears control state, the gripper value and the valid bits of the target and
// measured memories at once; there is no clearing pass. A low result.ready while a word
// is held freezes the whole joint pipeline, memory reads included, and sample.ready stays
// low until the last word of a tick has gone.
`timescale 1ns / 1ps

module wrapped_angle_lowpass_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [wal_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [wal_pkg::CFG_W-1:0]      wr_data,
	wal_in_if.sink                         sample,
	wal_out_if.source                      result
);
	import wal_pkg::*;

	`include "wrapped_angle_lowpass_filter_defines.svh"

	localparam int DIFF_W = ANGLE_W + 2;
	localparam int PROD_W = GAIN_W + ANGLE_W + 1;
	localparam int FRAC_W = GAIN_W;

	localparam logic signed [DIFF_W-1:0] PI_X     = DIFF_W'(PI_Q);
	localparam logic signed [DIFF_W-1:0] TWO_PI_X = DIFF_W'(TWO_PI_Q);
	localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (FRAC_W - 1);
	localparam logic [CNT_W-1:0]         CNT_JOINTS = CNT_W'(JOINT_COUNT);

	// One correction by a full turn at most is ever needed: both the raw error and the
	// updated value stay inside three half-turns of zero.
	function automatic logic signed [DIFF_W-1:0] wrap_turn(input logic signed [DIFF_W-1:0] x);
		logic signed [DIFF_W-1:0] y;
		y = x;
		if (x > PI_X) begin
			y = x - TWO_PI_X;
		end else if (x < -PI_X) begin
			y = x + TWO_PI_X;
		end
		return y;
	endfunction

	// Configuration registers.
	logic [GAIN_W-1:0] gain_q;
	logic [DZ_W-1:0]   dz_q;

	// State memories; target and measured read as zero until written.
	logic signed [ANGLE_W-1:0] tgt_mem  [JOINT_COUNT];
	logic signed [ANGLE_W-1:0] meas_mem [JOINT_COUNT];
	logic signed [ANGLE_W-1:0] filt_mem [JOINT_COUNT];
	logic [JOINT_COUNT-1:0]    tgt_vld_q;
	logic [JOINT_COUNT-1:0]    meas_vld_q;
	logic signed [ANGLE_W-1:0] gripper_q;

	logic tgt_seen_q, meas_seen_q, running_q, start_q, busy_q;
	logic [CNT_W-1:0] idx_q;

	// Input side.
	logic              in_acc, in_joint_ok, tick_go;
	logic [JIDX_W-1:0] in_jidx;
	kind_t             in_kind;

	assign sample.ready = !busy_q;
	assign in_acc       = sample.valid && sample.ready;
	assign in_kind      = kind_t'(sample.kind);
	assign in_joint_ok  = (32'(sample.joint) < JOINT_COUNT);
	assign in_jidx      = JIDX_W'(sample.joint);
	assign tick_go      = in_acc && (in_kind == KIND_TICK) &&
			(running_q || (tgt_seen_q && meas_seen_q));

	// Pipeline control: every stage moves only when the output register can take a word.
	logic out_v_q;
	logic adv, issue, issue_joint;
	logic [JIDX_W-1:0] rd_jidx;

	assign adv         = !out_v_q || result.ready;
	assign issue       = busy_q && adv && (idx_q <= CNT_JOINTS);
	assign issue_joint = idx_q < CNT_JOINTS;
	assign rd_jidx     = idx_q[JIDX_W-1:0];

	// Stage 1: registered memory read.
	logic                      v_s1, grip_s1, last_s1;
	logic [SLOT_W-1:0]         slot_s1;
	logic [JIDX_W-1:0]         jidx_s1;
	logic signed [ANGLE_W-1:0] tgt_s1, cur_s1;

	// Stage 2: wrapped error and dead-zone decision.
	logic                      v_s2, upd_s2, wr_s2, last_s2;
	logic [SLOT_W-1:0]         slot_s2;
	logic [JIDX_W-1:0]         jidx_s2;
	logic signed [ANGLE_W-1:0] err_s2, cur_s2;

	// Stage 3: gain product.
	logic                      v_s3, upd_s3, wr_s3, last_s3;
	logic [SLOT_W-1:0]         slot_s3;
	logic [JIDX_W-1:0]         jidx_s3;
	logic signed [ANGLE_W-1:0] cur_s3;
	logic signed [PROD_W-1:0]  prod_s3;

	// Output register.
	logic [SLOT_W-1:0]         slot_q;
	logic signed [ANGLE_W-1:0] pos_q;
	logic                      last_q;

	logic signed [DIFF_W-1:0]  diff, err_x;
	logic signed [ANGLE_W-1:0] err;
	logic [ANGLE_W-1:0]        mag;
	logic                      upd;

	logic signed [PROD_W-1:0]  rnd;
	logic signed [DIFF_W-1:0]  sum, sum_w;
	logic signed [ANGLE_W-1:0] new_pos;
	logic                      filt_we;

	always_comb begin
		diff  = DIFF_W'(tgt_s1) - DIFF_W'(cur_s1);
		err_x = wrap_turn(diff);
		err   = ANGLE_W'(err_x);
		mag   = err[ANGLE_W-1] ? ANGLE_W'(-err) : ANGLE_W'(err);
		upd   = !grip_s1 && (mag >= ANGLE_W'(dz_q));
	end

	// Round to nearest with ties upward: add half an LSB, then shift arithmetically.
	always_comb begin
		rnd     = (prod_s3 + HALF_LSB) >>> FRAC_W;
		sum     = DIFF_W'(cur_s3) + DIFF_W'(rnd);
		sum_w   = wrap_turn(sum);
		new_pos = upd_s3 ? ANGLE_W'(sum_w) : cur_s3;
	end

	// Every joint of a running tick writes back, which also makes the start copy.
	assign filt_we = adv && v_s3 && wr_s3;

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			dz_q   <= DZ_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_GAIN:      gain_q <= GAIN_W'(wr_data);
				REG_DEAD_ZONE: dz_q   <= DZ_W'(wr_data);
				default: ;
			endcase
		end
	end

	// Memory writes.
	always_ff @(posedge clk) begin
		if (in_acc && in_joint_ok && (in_kind == KIND_SET_TARGET)) begin
			tgt_mem[in_jidx] <= sample.angle;
		end
		if (in_acc && in_joint_ok && (in_kind == KIND_SET_MEASURED)) begin
			meas_mem[in_jidx] <= sample.angle;
		end
		if (filt_we) begin
			filt_mem[jidx_s3] <= new_pos;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_vld_q   <= '0;
			meas_vld_q  <= '0;
			gripper_q   <= '0;
			tgt_seen_q  <= 1'b0;
			meas_seen_q <= 1'b0;
			running_q   <= 1'b0;
			start_q     <= 1'b0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (in_acc && (in_kind == KIND_SET_TARGET)) begin
				tgt_seen_q <= 1'b1;
				if (in_joint_ok) begin
					tgt_vld_q[in_jidx] <= 1'b1;
				end
			end
			if (in_acc && (in_kind == KIND_SET_MEASURED)) begin
				meas_seen_q <= 1'b1;
				if (in_joint_ok) begin
					meas_vld_q[in_jidx] <= 1'b1;
				end
			end
			if (in_acc && (in_kind == KIND_SET_GRIPPER)) begin
				gripper_q <= sample.angle;
			end
			if (tick_go) begin
				busy_q    <= 1'b1;
				idx_q     <= '0;
				running_q <= 1'b1;
				start_q   <= !running_q;
			end else if (result.valid && result.ready && result.last) begin
				busy_q  <= 1'b0;
				start_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	// Stage valid bits and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
		end
	end

	// Stage payloads. The first filtered value of a starting tick comes from measured.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (issue) begin
				slot_s1 <= SLOT_W'(idx_q);
				jidx_s1 <= rd_jidx;
				grip_s1 <= !issue_joint;
				last_s1 <= !issue_joint;
				if (issue_joint) begin
					tgt_s1 <= tgt_vld_q[rd_jidx] ? tgt_mem[rd_jidx] : '0;
					if (start_q) begin
						cur_s1 <= meas_vld_q[rd_jidx] ? meas_mem[rd_jidx] : '0;
					end else begin
						cur_s1 <= filt_mem[rd_jidx];
					end
				end else begin
					tgt_s1 <= '0;
					cur_s1 <= gripper_q;
				end
			end

			err_s2  <= err;
			cur_s2  <= cur_s1;
			upd_s2  <= upd;
			wr_s2   <= !grip_s1;
			slot_s2 <= slot_s1;
			jidx_s2 <= jidx_s1;
			last_s2 <= last_s1;

			prod_s3 <= $signed({1'b0, gain_q}) * PROD_W'(err_s2);
			cur_s3  <= cur_s2;
			upd_s3  <= upd_s2;
			wr_s3   <= wr_s2;
			slot_s3 <= slot_s2;
			jidx_s3 <= jidx_s2;
			last_s3 <= last_s2;

			pos_q  <= new_pos;
			slot_q <= slot_s3;
			last_q <= last_s3;
		end
	end

	assign result.valid    = out_v_q;
	assign result.slot     = slot_q;
	assign result.position = pos_q;
	assign result.last     = last_q;

	`WAL_ASSERT_NOW(a_out_only_busy, result.valid, busy_q, "result word outside a tick")
	`WAL_ASSERT_NEXT(a_last_ends_tick, result.valid && result.ready && result.last, !busy_q,
		"tick still busy after its last word")
	`WAL_ASSERT_NOW(a_write_running, filt_we, running_q, "filtered memory written before start")
	`WAL_ASSERT_NOW(a_idx_bound, busy_q, idx_q <= CNT_JOINTS + CNT_W'(1),
		"joint walk ran past the gripper slot")
	`WAL_ASSERT_NOW(a_stage_busy, v_s1 || v_s2 || v_s3, busy_q, "pipeline active while idle")

endmodule
